[rtl/rrss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rrss_pkg;

	localparam int REQ_W        = 2;
	localparam int BURST_PORT_W = 16;
	localparam int QUANTUM_W    = 16;
	localparam int ID_W         = 7;
	localparam int COUNT_OUT_W  = 7;
	localparam int TIME_OUT_W   = 22;
	localparam int TOTAL_OUT_W  = 28;
	localparam int ELAPSED_W    = 23;
	localparam int SUM_W        = 29;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [SUM_W-1:0]     SUM_MAX     = '1;

	// Request codes on the req_type port.
	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// Depth of the command queue between front and back.
	localparam int CMD_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_RUN,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [BURST_PORT_W-1:0] burst;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_GRANT,
		ST_WAIT,
		ST_SUM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]        process_id;
		logic [TIME_OUT_W-1:0]  slice_end_time;
		logic                   finished;
		logic [TIME_OUT_W-1:0]  turnaround_time;
		logic [TIME_OUT_W-1:0]  waiting_time;
		logic                   all_done;
		logic [TOTAL_OUT_W-1:0] total_waiting;
		logic [TOTAL_OUT_W-1:0] total_turnaround;
		logic [COUNT_OUT_W-1:0] process_count;
	} res_t;

endpackage

`default_nettype wire

[rtl/round_robin_slice_scheduler_top.sv]
// A load or clear transaction is written into the command queue and takes effect when the
// back end, in its idle state, pops it. A run scans the table from the ring pointer, reading
// up to MAX_PROCESSES entries, grants a slice and, when the slice finishes its process, also
// computes the waiting time and the totals before the result is registered at the ports.
// The back end takes one load or clear a cycle while idle, and no new command while a run is
// in flight. A result not yet popped stalls the back end. Reset clears control state and sets time_quantum to 1.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_slice_scheduler_top #(
	parameter int MAX_PROCESSES = 64,
	parameter int BURST_WIDTH   = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                push,
	output logic                               full,
	input  wire [rrss_pkg::REQ_W-1:0]          req_type,
	input  wire [rrss_pkg::BURST_PORT_W-1:0]   burst_time,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [rrss_pkg::QUANTUM_W-1:0]      cfg_data,
	output logic                               empty,
	input  wire                                pop,
	output logic [rrss_pkg::ID_W-1:0]          process_id,
	output logic [rrss_pkg::TIME_OUT_W-1:0]    slice_end_time,
	output logic                               finished,
	output logic [rrss_pkg::TIME_OUT_W-1:0]    turnaround_time,
	output logic [rrss_pkg::TIME_OUT_W-1:0]    waiting_time,
	output logic                               all_done,
	output logic [rrss_pkg::TOTAL_OUT_W-1:0]   total_waiting,
	output logic [rrss_pkg::TOTAL_OUT_W-1:0]   total_turnaround,
	output logic [rrss_pkg::COUNT_OUT_W-1:0]   process_count
);

	import rrss_pkg::*;

	logic [QUANTUM_W-1:0] time_quantum_q;
	logic                 cmd_valid;
	cmd_t                 cmd;
	logic                 cmd_pop;
	res_t                 res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_quantum_q <= QUANTUM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			time_quantum_q <= cfg_data;
		end
	end

	rrss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.req_type   (req_type),
		.burst_time (burst_time),
		.full       (full),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	rrss_back #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.BURST_WIDTH   (BURST_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.time_quantum (time_quantum_q),
		.pop          (pop),
		.empty        (empty),
		.res          (res)
	);

	assign process_id       = res.process_id;
	assign slice_end_time   = res.slice_end_time;
	assign finished         = res.finished;
	assign turnaround_time  = res.turnaround_time;
	assign waiting_time     = res.waiting_time;
	assign all_done         = res.all_done;
	assign total_waiting    = res.total_waiting;
	assign total_turnaround = res.total_turnaround;
	assign process_count    = res.process_count;

	a_done_no_slice: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && all_done) |-> (process_id == '0 && !finished))
		else $error("all_done result carries a slice");

	a_finish_time: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && finished) |-> (turnaround_time == slice_end_time && !all_done))
		else $error("finished slice has wrong turnaround time");

	a_unfinished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !finished) |-> (turnaround_time == '0 && waiting_time == '0))
		else $error("unfinished slice carries completion times");

endmodule

`default_nettype wire

[rtl/rrss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/rrss_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrss_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               push,
	input  wire [rrss_pkg::REQ_W-1:0]         req_type,
	input  wire [rrss_pkg::BURST_PORT_W-1:0]  burst_time,
	output logic                              full,
	output logic                              cmd_valid,
	output rrss_pkg::cmd_t                    cmd,
	input  wire                               cmd_pop
);

	import rrss_pkg::*;

	localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int NW = $clog2(CMD_DEPTH + 1);

	cmd_t          slot_q [CMD_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;

	logic   accept;
	logic   keep;
	op_t    op_dec;
	logic   do_wr;
	logic   do_rd;

	assign full      = (fill_q == NW'(CMD_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = slot_q[rd_ptr_q];
	assign accept    = push && !full;

	// Unused request codes are taken from the port and dropped here.
	always_comb begin
		keep   = 1'b1;
		op_dec = OP_LOAD;
		unique case (req_type)
			REQ_LOAD:  op_dec = OP_LOAD;
			REQ_RUN:   op_dec = OP_RUN;
			REQ_CLEAR: op_dec = OP_CLEAR;
			default:   keep = 1'b0;
		endcase
	end

	assign do_wr = accept && keep;
	assign do_rd = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + NW'(1);
			end else if (!do_wr && do_rd) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q].op    <= op_dec;
			slot_q[wr_ptr_q].burst <= burst_time;
		end
	end

endmodule

`default_nettype wire

[rtl/rrss_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrss_back #(
	parameter int MAX_PROCESSES = 64,
	parameter int BURST_WIDTH   = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cmd_valid,
	input  wire rrss_pkg::cmd_t             cmd,
	output logic                            cmd_pop,
	input  wire [rrss_pkg::QUANTUM_W-1:0]   time_quantum,
	input  wire                             pop,
	output logic                            empty,
	output rrss_pkg::res_t                  res
);

	import rrss_pkg::*;

	localparam int AW  = $clog2(MAX_PROCESSES);
	localparam int CW  = $clog2(MAX_PROCESSES + 1);
	localparam int BW  = BURST_WIDTH;
	localparam int GW  = (BW > QUANTUM_W) ? BW : QUANTUM_W;
	localparam int EW  = ((GW > ELAPSED_W) ? GW : ELAPSED_W) + 1;
	localparam int WW  = (BW > ELAPSED_W) ? BW : ELAPSED_W;

	state_t state_q;
	state_t state_d;

	logic [CW-1:0]        count_q;
	logic [AW-1:0]        ptr_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [SUM_W-1:0]     wait_sum_q;
	logic [SUM_W-1:0]     turn_sum_q;
	logic                 out_valid_q;
	res_t                 res_q;

	logic [AW-1:0]        j_q;
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        j_s1;
	logic                 valid_s1;
	logic [AW-1:0]        idx_q;
	logic [BW-1:0]        rem_q;
	logic [BW-1:0]        burst_q;
	logic                 found_q;
	logic                 done_q;
	logic [ELAPSED_W-1:0] wait_q;

	logic [BW-1:0] rem_rd;
	logic [BW-1:0] burst_rd;

	logic          rem_we;
	logic [AW-1:0] rem_waddr;
	logic [BW-1:0] rem_wdata;
	logic          burst_we;
	logic          out_load;

	logic                 issue;
	logic                 hit;
	logic                 table_full;
	logic [QUANTUM_W-1:0] q_eff;
	logic                 slice_done;
	logic [GW-1:0]        grant;
	logic [EW-1:0]        elapsed_sum;
	logic [WW-1:0]        wait_diff;
	logic                 wait_pos;
	logic [SUM_W:0]       turn_add;
	logic [SUM_W:0]       wait_add;
	logic [CW-1:0]        start;

	rrss_ram #(.WIDTH(BW), .DEPTH(MAX_PROCESSES)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (j_q),
		.rdata (rem_rd)
	);

	rrss_ram #(.WIDTH(BW), .DEPTH(MAX_PROCESSES)) u_burst_ram (
		.clk   (clk),
		.we    (burst_we),
		.waddr (AW'(count_q)),
		.wdata (BW'(cmd.burst)),
		.raddr (j_q),
		.rdata (burst_rd)
	);

	assign table_full = (count_q >= CW'(MAX_PROCESSES));
	assign issue      = (cnt_q < count_q);
	assign hit        = valid_s1 && (rem_rd != '0);
	assign start      = (CW'(ptr_q) < count_q) ? CW'(ptr_q) : '0;

	assign q_eff      = (time_quantum == '0) ? QUANTUM_W'(1) : time_quantum;
	assign slice_done = (GW'(rem_q) <= GW'(q_eff));
	assign grant      = slice_done ? GW'(rem_q) : GW'(q_eff);
	assign elapsed_sum = EW'(elapsed_q) + EW'(grant);

	assign wait_pos  = (WW'(elapsed_q) >= WW'(burst_q));
	assign wait_diff = WW'(elapsed_q) - WW'(burst_q);

	assign turn_add = (SUM_W + 1)'(turn_sum_q) + (SUM_W + 1)'(elapsed_q);
	assign wait_add = (SUM_W + 1)'(wait_sum_q) + (SUM_W + 1)'(wait_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.op == OP_RUN) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_GRANT;
				end else if (!issue && !valid_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_GRANT: state_d = slice_done ? ST_WAIT : ST_EMIT;
			ST_WAIT:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || pop) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		rem_we    = 1'b0;
		rem_waddr = AW'(count_q);
		rem_wdata = BW'(cmd.burst);
		burst_we  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_pop  = cmd_valid;
				rem_we   = cmd_valid && (cmd.op == OP_LOAD) && !table_full;
				burst_we = rem_we;
			end
			ST_GRANT: begin
				rem_we    = 1'b1;
				rem_waddr = idx_q;
				rem_wdata = rem_q - BW'(grant);
			end
			ST_EMIT:  out_load = !out_valid_q || pop;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			elapsed_q   <= '0;
			wait_sum_q  <= '0;
			turn_sum_q  <= '0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && cmd_valid) begin
				case (cmd.op)
					OP_LOAD: begin
						if (!table_full) begin
							count_q <= count_q + CW'(1);
						end
					end
					OP_CLEAR: begin
						count_q    <= '0;
						ptr_q      <= '0;
						elapsed_q  <= '0;
						wait_sum_q <= '0;
						turn_sum_q <= '0;
					end
					default: begin
					end
				endcase
			end
			valid_s1 <= (state_q == ST_SCAN) && issue && !hit;
			if (state_q == ST_GRANT) begin
				elapsed_q <= (elapsed_sum > EW'(ELAPSED_MAX)) ? ELAPSED_MAX
				                                              : ELAPSED_W'(elapsed_sum);
				ptr_q <= (CW'(idx_q) + CW'(1) >= CW'(MAX_PROCESSES)) ? '0
				                                                     : idx_q + AW'(1);
			end
			if (state_q == ST_SUM) begin
				turn_sum_q <= (turn_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX
				                                                 : SUM_W'(turn_add);
				wait_sum_q <= (wait_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX
				                                                 : SUM_W'(wait_add);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan pipeline: a read is issued from j_q each cycle while entries remain, and its data is checked in the next cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			j_q     <= AW'(start);
			cnt_q   <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
			wait_q  <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (issue) begin
				j_q   <= (CW'(j_q) + CW'(1) == count_q) ? '0 : j_q + AW'(1);
				cnt_q <= cnt_q + CW'(1);
			end
			j_s1 <= j_q;
			if (hit) begin
				idx_q   <= j_s1;
				rem_q   <= rem_rd;
				burst_q <= burst_rd;
				found_q <= 1'b1;
			end
		end
		if (state_q == ST_GRANT) begin
			done_q <= slice_done;
		end
		if (state_q == ST_WAIT) begin
			wait_q <= wait_pos ? ELAPSED_W'(wait_diff) : '0;
		end
		if (out_load) begin
			res_q.process_id       <= found_q ? ID_W'(CW'(idx_q) + CW'(1)) : '0;
			res_q.slice_end_time   <= elapsed_q[TIME_OUT_W-1:0];
			res_q.finished         <= done_q;
			res_q.turnaround_time  <= done_q ? elapsed_q[TIME_OUT_W-1:0] : '0;
			res_q.waiting_time     <= wait_q[TIME_OUT_W-1:0];
			res_q.all_done         <= !found_q;
			res_q.total_waiting    <= wait_sum_q[TOTAL_OUT_W-1:0];
			res_q.total_turnaround <= turn_sum_q[TOTAL_OUT_W-1:0];
			res_q.process_count    <= COUNT_OUT_W'(count_q);
		end
	end

	assign empty = !out_valid_q;
	assign res   = res_q;

endmodule

`default_nettype wire

[verif/round_robin_slice_scheduler_top_test.sv]
`timescale 1ns / 1ps

module round_robin_slice_scheduler_top_test;

	import rrss_pkg::*;

	localparam int          TABLE_DEPTH  = 64;
	localparam int          SETTLE_CYCLES = 100;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          STALL_LIMIT  = 5000;
	localparam int          PHASE_ITEMS  = 290;
	localparam int          PHASE_COUNT  = 6;
	// The fourth request code has no meaning and must be dropped by the block.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	class slice_board;
		res_t                    slices_due[$];
		logic [BURST_PORT_W-1:0] burst_tab[TABLE_DEPTH];
		logic [BURST_PORT_W-1:0] remain_tab[TABLE_DEPTH];
		int unsigned             loaded;
		int unsigned             ring_ptr;
		longint unsigned         elapsed;
		longint unsigned         wait_sum;
		longint unsigned         turn_sum;
		logic [QUANTUM_W-1:0]    quantum;
		int                      errors;

		function new();
			wipe();
			quantum = QUANTUM_W'(1);
			errors = 0;
		endfunction

		function void wipe();
			loaded = 0;
			ring_ptr = 0;
			elapsed = 0;
			wait_sum = 0;
			turn_sum = 0;
		endfunction

		function void set_quantum(logic [QUANTUM_W-1:0] q);
			quantum = q;
		endfunction

		function longint unsigned sat(longint unsigned v, longint unsigned lim);
			return (v > lim) ? lim : v;
		endfunction

		// Predicts the slice produced by one accepted request, if any.
		function void note_request(logic [REQ_W-1:0] r, logic [BURST_PORT_W-1:0] b);
			int unsigned     start;
			int unsigned     j;
			int unsigned     idx;
			bit              found;
			bit              done;
			longint unsigned q;
			longint unsigned grant;
			longint unsigned turn;
			longint unsigned wait_amt;
			res_t            res;
			case (r)
				REQ_LOAD: begin
					if (loaded < TABLE_DEPTH) begin
						burst_tab[loaded] = b;
						remain_tab[loaded] = b;
						loaded++;
					end
				end
				REQ_CLEAR: wipe();
				REQ_RUN: begin
					found = 0;
					done = 0;
					idx = 0;
					turn = 0;
					wait_amt = 0;
					start = (ring_ptr < loaded) ? ring_ptr : 0;
					for (int i = 0; i < loaded; i++) begin
						j = start + i;
						if (j >= loaded)
							j -= loaded;
						if (!found && remain_tab[j] != 0) begin
							idx = j;
							found = 1;
						end
					end
					res = '0;
					if (!found) begin
						res.all_done = 1'b1;
					end else begin
						q = (quantum == 0) ? 1 : quantum;
						if (remain_tab[idx] <= q) begin
							grant = remain_tab[idx];
							done = 1;
						end else begin
							grant = q;
						end
						remain_tab[idx] = BURST_PORT_W'(remain_tab[idx] - grant);
						elapsed = sat(elapsed + grant, ELAPSED_MAX);
						if (done) begin
							turn = elapsed;
							wait_amt = (turn >= burst_tab[idx]) ? turn - burst_tab[idx] : 0;
							turn_sum = sat(turn_sum + turn, SUM_MAX);
							wait_sum = sat(wait_sum + wait_amt, SUM_MAX);
						end
						ring_ptr = (idx + 1 >= TABLE_DEPTH) ? 0 : idx + 1;
						res.process_id = ID_W'(idx + 1);
						res.finished = done;
						res.turnaround_time = turn[TIME_OUT_W-1:0];
						res.waiting_time = wait_amt[TIME_OUT_W-1:0];
					end
					res.slice_end_time = elapsed[TIME_OUT_W-1:0];
					res.total_waiting = wait_sum[TOTAL_OUT_W-1:0];
					res.total_turnaround = turn_sum[TOTAL_OUT_W-1:0];
					res.process_count = loaded[COUNT_OUT_W-1:0];
					slices_due.push_back(res);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, longint unsigned exp, longint unsigned act);
			if (exp != act) begin
				$error("%s: expected %0d, got %0d", name, exp, act);
				errors++;
			end
		endfunction

		function void check_slice(res_t got);
			res_t exp;
			if (slices_due.size() == 0) begin
				$error("result popped with no slice outstanding");
				errors++;
				return;
			end
			exp = slices_due.pop_front();
			compare_field("process_id", exp.process_id, got.process_id);
			compare_field("slice_end_time", exp.slice_end_time, got.slice_end_time);
			compare_field("finished", exp.finished, got.finished);
			compare_field("turnaround_time", exp.turnaround_time, got.turnaround_time);
			compare_field("waiting_time", exp.waiting_time, got.waiting_time);
			compare_field("all_done", exp.all_done, got.all_done);
			compare_field("total_waiting", exp.total_waiting, got.total_waiting);
			compare_field("total_turnaround", exp.total_turnaround, got.total_turnaround);
			compare_field("process_count", exp.process_count, got.process_count);
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic [REQ_W-1:0]        req_type;
	logic [BURST_PORT_W-1:0] burst_time;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [QUANTUM_W-1:0]    cfg_data;
	logic                    empty;
	logic                    pop;
	logic [ID_W-1:0]         process_id;
	logic [TIME_OUT_W-1:0]   slice_end_time;
	logic                    finished;
	logic [TIME_OUT_W-1:0]   turnaround_time;
	logic [TIME_OUT_W-1:0]   waiting_time;
	logic                    all_done;
	logic [TOTAL_OUT_W-1:0]  total_waiting;
	logic [TOTAL_OUT_W-1:0]  total_turnaround;
	logic [COUNT_OUT_W-1:0]  process_count;

	slice_board board;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         phase_items;
	bit         hold_request;
	int         hold_left;
	int         quiet_cycles;

	round_robin_slice_scheduler_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.req_type         (req_type),
		.burst_time       (burst_time),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.empty            (empty),
		.pop              (pop),
		.process_id       (process_id),
		.slice_end_time   (slice_end_time),
		.finished         (finished),
		.turnaround_time  (turnaround_time),
		.waiting_time     (waiting_time),
		.all_done         (all_done),
		.total_waiting    (total_waiting),
		.total_turnaround (total_turnaround),
		.process_count    (process_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_item(logic [REQ_W-1:0] r, logic [BURST_PORT_W-1:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req_type <= r;
		burst_time <= b;
		do @(posedge clk); while (full);
		board.note_request(r, b);
		if (r != REQ_UNUSED)
			phase_items++;
	endtask

	task automatic drain_and_settle();
		push <= 1'b0;
		while (board.slices_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_quantum(logic [QUANTUM_W-1:0] q);
		cfg_valid <= 1'b1;
		cfg_data <= q;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_quantum(q);
	endtask

	function automatic logic [BURST_PORT_W-1:0] pick_burst();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return '0;
		if (roll < 15)
			return '1;
		if (roll < 20)
			return BURST_PORT_W'($urandom);
		return BURST_PORT_W'($urandom_range(1, 12));
	endfunction

	// An optional clear, a batch of loads, then a run of slices with late loads,
	// clears and dropped requests mixed in.
	task automatic run_sequence(bit fill_table);
		int n_load;
		int n_run;
		int roll;
		if (fill_table || $urandom_range(0, 2) != 0)
			send_item(REQ_CLEAR, BURST_PORT_W'($urandom));
		if (fill_table || $urandom_range(0, 24) == 0)
			n_load = $urandom_range(62, 68);
		else
			n_load = $urandom_range(1, 8);
		repeat (n_load) send_item(REQ_LOAD, pick_burst());
		n_run = $urandom_range(1, 3 * n_load + 4);
		repeat (n_run) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				send_item(REQ_LOAD, pick_burst());
			else if (roll < 7)
				send_item(REQ_UNUSED, BURST_PORT_W'($urandom));
			else if (roll < 8)
				send_item(REQ_CLEAR, BURST_PORT_W'($urandom));
			else
				send_item(REQ_RUN, BURST_PORT_W'($urandom));
		end
	endtask

	task automatic directed_items();
		send_item(REQ_RUN, '0);
		send_item(REQ_LOAD, '1);
		send_item(REQ_LOAD, '0);
		send_item(REQ_LOAD, 16'd2);
		send_item(REQ_LOAD, 16'd1);
		repeat (4) send_item(REQ_RUN, '0);
		send_item(REQ_UNUSED, '1);
		send_item(REQ_LOAD, 16'd3);
		repeat (4) send_item(REQ_RUN, '1);
		send_item(REQ_CLEAR, '0);
		send_item(REQ_RUN, '0);
		send_item(REQ_LOAD, 16'd1);
		repeat (2) send_item(REQ_RUN, '0);
	endtask

	initial begin
		board = new();
		arst_n <= 1'b0;
		push <= 1'b0;
		req_type <= REQ_LOAD;
		burst_time <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		pop <= 1'b0;
		hold_request = 0;
		hold_left = 0;
		send_idle_pct = 21;
		recv_idle_pct = 64;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase < 2) begin
				send_idle_pct = 21;
				recv_idle_pct = 64;
			end else if (phase < 4) begin
				send_idle_pct = 64;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase > 0) begin
				drain_and_settle();
				case (phase)
					1: write_quantum('0);
					2: write_quantum('1);
					3: write_quantum(16'd3);
					4: write_quantum(QUANTUM_W'($urandom_range(1, 65535)));
					default: write_quantum(16'd1);
				endcase
			end
			phase_items = 0;
			if (phase == 0)
				directed_items();
			if (phase == 4)
				hold_request = 1;
			run_sequence(phase == 2);
			while (phase_items < PHASE_ITEMS)
				run_sequence(0);
		end

		drain_and_settle();
		if (board.slices_due.size() != 0) begin
			$error("%0d expected slices never arrived", board.slices_due.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("round_robin_slice_scheduler_top: match");
		else
			$display("round_robin_slice_scheduler_top: mismatch");
		$finish;
	end

	// Result side: check on the edge where the transaction completes, then
	// choose pop for the next cycle.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				board.check_slice('{process_id, slice_end_time, finished, turnaround_time,
					waiting_time, all_done, total_waiting, total_turnaround, process_count});
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("round_robin_slice_scheduler_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
